// File: src/das_pkg.sv
// ---------------------------------------------------------------------------
// das_pkg - dryer actuator sequencer shared types and constants
// Item layouts, configuration register indexes and fixed widths.
// ---------------------------------------------------------------------------
package das_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned TEMP_BITS = 16;

  localparam int unsigned HUM_W      = 10;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned SPREAD_W   = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // vent times are kept in ms, scaled when the register is written
  localparam int unsigned DUR_MS_W = 26;
  localparam int unsigned INT_MS_W = 32;
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned MS_PER_MIN = 60000;

  localparam int unsigned CMP_W = (TIME_BITS > INT_MS_W) ? TIME_BITS : INT_MS_W;
  localparam int unsigned SPR_W = (TEMP_BITS > SPREAD_W) ? TEMP_BITS : SPREAD_W;

  localparam int unsigned BEEP_PERIOD_MS = 1000;
  localparam int unsigned BEEP_LEN_MS    = 200;
  localparam int unsigned BEEP_ARM_MS    = 1001;

  localparam int unsigned RST_TARGET_HUM = 400;
  localparam int unsigned RST_VENT_DUR   = 30;
  localparam int unsigned RST_VENT_INT   = 10;
  localparam int unsigned RST_SPREAD_ON  = 48;
  localparam int unsigned RST_SPREAD_OFF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_HUM = 3'd0,
    CFG_VENT_DUR   = 3'd1,
    CFG_VENT_INT   = 3'd2,
    CFG_SPREAD_ON  = 3'd3,
    CFG_SPREAD_OFF = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TIME_BITS-1:0]      now_ms;
    logic                      test_mode;
    logic                      drying_active;
    logic                      alarm_state;
    logic signed [LEVEL_W-1:0] heater_level;
    logic                      boost_phase;
    logic signed [TEMP_BITS-1:0] temp_a;
    logic signed [TEMP_BITS-1:0] temp_b;
    logic signed [TEMP_BITS-1:0] temp_c;
    logic signed [TEMP_BITS-1:0] temp_d;
    logic [HUM_W-1:0]          humidity;
    logic                      alarm_play;
  } in_item_t;

  typedef struct packed {
    logic heater_main;
    logic heater_aux1;
    logic heater_aux2;
    logic heater_any;
    logic chamber_fan;
    logic vent_fan;
    logic buzzer;
  } out_item_t;

endpackage

// File: src/dryer_actuator_sequencer_core.sv
// ---------------------------------------------------------------------------
// dryer_actuator_sequencer_core - heater, fan, vent and buzzer sequencer
//
// One input item per control tick; one result item per input item.
// Input channel in_valid_i/in_ready_o carries the tick (time, mode flags,
// heater level, four chamber temperatures, humidity, alarm request).
// Output channel out_valid_o/out_ready_i carries the seven drive bits.
// Configuration channel cfg_valid_i/cfg_ready_o writes one register per
// item by index; cfg_ready_o is always high, unknown indexes are dropped.
// The result is registered: it enters the result register, or the skid register while the result register is held.
// Throughput: one item per cycle while in_ready_o is high; the whole step is one combinational
// pass from the accepted item and the held state into the state and
// result registers.
// A two-entry output buffer (result register plus skid register) lets an
// item be taken while a result waits; in_ready_o drops only when both
// entries are full, i.e. after the receiver stalls for two items.
// Reset clears all drive state and the buffer, and loads the register
// defaults (target 40.0 %, vent 30 s every 10 min, spread 3.0/1.0 degC).
// ---------------------------------------------------------------------------
module dryer_actuator_sequencer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  das_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output das_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [das_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [das_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import das_pkg::*;

  // configuration
  logic [HUM_W-1:0]    target_q;
  logic [DUR_MS_W-1:0] dur_ms_q;
  logic [INT_MS_W-1:0] int_ms_q;
  logic [SPREAD_W-1:0] spr_on_q;
  logic [SPREAD_W-1:0] spr_off_q;

  // sequencer state
  logic [2:0]           heater_q, heater_d;
  logic                 cfan_q, cfan_d;
  logic                 vent_q, vent_d;
  logic                 vstart_q, vstart_d;
  logic [TIME_BITS-1:0] vtime_q, vtime_d;
  logic                 armed_q, armed_d;
  logic                 beep_q, beep_d;
  logic [TIME_BITS-1:0] lbeep_q, lbeep_d;
  logic                 buzz_q, buzz_d;

  // output buffer
  logic      ovalid_q, ovalid_d;
  out_item_t odata_q, odata_d;
  logic      svalid_q, svalid_d;
  out_item_t sdata_q, sdata_d;

  logic      acc, pop, ofree;
  out_item_t res;

  // step datapath
  logic [TIME_BITS-1:0]        now;
  logic signed [LEVEL_W-1:0]   lvl;
  logic signed [TEMP_BITS-1:0] mx_ab, mn_ab, mx_cd, mn_cd, mx, mn;
  logic [TEMP_BITS-1:0]        diff_s;
  logic [SPR_W-1:0]            spread;
  logic [CMP_W-1:0]            vel;
  logic [TIME_BITS-1:0]        bel;
  logic                        bstart, bbeep;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !svalid_q;
  assign acc         = in_valid_i && !svalid_q;
  assign pop         = ovalid_q && out_ready_i;
  assign ofree       = !ovalid_q || pop;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  assign now = in_data_i.now_ms;
  assign lvl = in_data_i.heater_level;

  // temperature spread, max minus min
  assign mx_ab  = (in_data_i.temp_a > in_data_i.temp_b) ? in_data_i.temp_a : in_data_i.temp_b;
  assign mn_ab  = (in_data_i.temp_a < in_data_i.temp_b) ? in_data_i.temp_a : in_data_i.temp_b;
  assign mx_cd  = (in_data_i.temp_c > in_data_i.temp_d) ? in_data_i.temp_c : in_data_i.temp_d;
  assign mn_cd  = (in_data_i.temp_c < in_data_i.temp_d) ? in_data_i.temp_c : in_data_i.temp_d;
  assign mx     = (mx_ab > mx_cd) ? mx_ab : mx_cd;
  assign mn     = (mn_ab < mn_cd) ? mn_ab : mn_cd;
  // max minus min is never negative and fits the reading width
  assign diff_s = $unsigned(mx - mn);
  assign spread = SPR_W'(diff_s);

  assign vel = CMP_W'(now - vtime_q);

  always_comb begin
    heater_d = heater_q;
    cfan_d   = cfan_q;
    vent_d   = vent_q;
    vstart_d = vstart_q;
    vtime_d  = vtime_q;
    armed_d  = armed_q;
    beep_d   = beep_q;
    lbeep_d  = lbeep_q;
    buzz_d   = buzz_q;
    bel      = '0;
    bstart   = 1'b0;
    bbeep    = 1'b0;

    // alarm request, applied also in test mode
    if (in_data_i.alarm_play && !armed_q) begin
      armed_d = 1'b1;
      lbeep_d = now - TIME_BITS'(BEEP_ARM_MS);
    end else if (!in_data_i.alarm_play) begin
      armed_d = 1'b0;
      beep_d  = 1'b0;
      buzz_d  = 1'b0;
    end

    if (!in_data_i.test_mode) begin
      // heaters
      if (!in_data_i.drying_active || in_data_i.alarm_state) begin
        heater_d = 3'b000;
      end else if (lvl == LEVEL_W'(1)) begin
        heater_d = 3'b001;
      end else if (lvl == LEVEL_W'(2)) begin
        heater_d = 3'b110;
      end else if (lvl > $signed(LEVEL_W'(2))) begin
        heater_d = 3'b111;
      end else begin
        heater_d = 3'b000;
      end

      // chamber fan
      if (in_data_i.boost_phase) begin
        cfan_d = 1'b1;
      end else if (in_data_i.drying_active) begin
        if (!cfan_q && (spread > SPR_W'(spr_on_q))) begin
          cfan_d = 1'b1;
        end else if (cfan_q && (spread < SPR_W'(spr_off_q))) begin
          cfan_d = 1'b0;
        end
      end else begin
        cfan_d = 1'b0;
      end

      // vent cycle
      if (in_data_i.drying_active && (in_data_i.humidity > target_q)) begin
        if (vent_q) begin
          if (vel >= CMP_W'(dur_ms_q)) begin
            vent_d = 1'b0;
          end
        end else if (!vstart_q || (vel >= CMP_W'(int_ms_q))) begin
          vent_d   = 1'b1;
          vstart_d = 1'b1;
          vtime_d  = now;
        end
      end else begin
        vent_d   = 1'b0;
        vstart_d = 1'b0;
        vtime_d  = '0;
      end

      // beep
      if (armed_d) begin
        bel    = now - lbeep_d;
        bstart = bel > TIME_BITS'(BEEP_PERIOD_MS);
        bbeep  = bstart || beep_d;
        if (bstart) begin
          lbeep_d = now;
          bel     = '0;
        end
        if (bbeep && (bel > TIME_BITS'(BEEP_LEN_MS))) begin
          beep_d = 1'b0;
          buzz_d = 1'b0;
        end else if (bstart) begin
          beep_d = 1'b1;
          buzz_d = 1'b1;
        end
      end else begin
        buzz_d = 1'b0;
      end
    end
  end

  always_comb begin
    res.heater_main = heater_d[0];
    res.heater_aux1 = heater_d[1];
    res.heater_aux2 = heater_d[2];
    res.heater_any  = |heater_d;
    res.chamber_fan = cfan_d;
    res.vent_fan    = vent_d;
    res.buzzer      = buzz_d;
  end

  always_comb begin
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    svalid_d = svalid_q;
    sdata_d  = sdata_q;
    if (pop) begin
      ovalid_d = 1'b0;
    end
    if (svalid_q && ofree) begin
      ovalid_d = 1'b1;
      odata_d  = sdata_q;
      svalid_d = 1'b0;
    end
    if (acc) begin
      if (ofree) begin
        ovalid_d = 1'b1;
        odata_d  = res;
      end else begin
        svalid_d = 1'b1;
        sdata_d  = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= HUM_W'(RST_TARGET_HUM);
      dur_ms_q  <= DUR_MS_W'(RST_VENT_DUR * MS_PER_SEC);
      int_ms_q  <= INT_MS_W'(RST_VENT_INT * MS_PER_MIN);
      spr_on_q  <= SPREAD_W'(RST_SPREAD_ON);
      spr_off_q <= SPREAD_W'(RST_SPREAD_OFF);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_HUM: target_q  <= cfg_data_i[HUM_W-1:0];
        CFG_VENT_DUR:   dur_ms_q  <= DUR_MS_W'(cfg_data_i) * DUR_MS_W'(MS_PER_SEC);
        CFG_VENT_INT:   int_ms_q  <= INT_MS_W'(cfg_data_i) * INT_MS_W'(MS_PER_MIN);
        CFG_SPREAD_ON:  spr_on_q  <= cfg_data_i[SPREAD_W-1:0];
        CFG_SPREAD_OFF: spr_off_q <= cfg_data_i[SPREAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q <= '0;
      cfan_q   <= 1'b0;
      vent_q   <= 1'b0;
      vstart_q <= 1'b0;
      vtime_q  <= '0;
      armed_q  <= 1'b0;
      beep_q   <= 1'b0;
      lbeep_q  <= '0;
      buzz_q   <= 1'b0;
    end else if (acc) begin
      heater_q <= heater_d;
      cfan_q   <= cfan_d;
      vent_q   <= vent_d;
      vstart_q <= vstart_d;
      vtime_q  <= vtime_d;
      armed_q  <= armed_d;
      beep_q   <= beep_d;
      lbeep_q  <= lbeep_d;
      buzz_q   <= buzz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      svalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      svalid_q <= svalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    sdata_q <= sdata_d;
  end

endmodule

// File: src/das_checker.sv
// ---------------------------------------------------------------------------
// das_checker - port-level checks for the dryer actuator sequencer
// Watches the top level's channels; attached to it by bind.
// ---------------------------------------------------------------------------
module das_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input das_pkg::out_item_t  out_data_o
);
  import das_pkg::*;

  // heater LED follows the three drives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.heater_any ==
      (out_data_o.heater_main || out_data_o.heater_aux1 || out_data_o.heater_aux2)))
    else $error("heater_any does not match heater drives");

  // auxiliary heaters always switch as a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.heater_aux1 == out_data_o.heater_aux2))
    else $error("auxiliary heaters out of step");

  // input stalls only while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

endmodule

bind dryer_actuator_sequencer_core das_checker u_das_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: test/tb_dryer_actuator_sequencer_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dryer_actuator_sequencer_core - self-checking bench for the sequencer
// Drives control ticks through the input channel and register writes
// through the config channel. Each tick is run through a bit-level
// predictor of the heater, fan, vent and buzzer state. Every drive result
// is checked field by field against the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_dryer_actuator_sequencer_core;
  import das_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 500;

  class actuator_scoreboard;
    logic [HUM_W-1:0]      target_hum;
    logic [15:0]           vent_dur_s;
    logic [15:0]           vent_int_min;
    logic [SPREAD_W-1:0]   spr_on;
    logic [SPREAD_W-1:0]   spr_off;

    logic [2:0]            heaters;
    bit                    cfan, vfan, venting, vent_started, armed, beeping, buzz;
    logic [TIME_BITS-1:0]  vent_t0, last_beep;

    out_item_t             drives_due[$];
    string                 field_name[7];
    int unsigned           ticks, checked, errors;

    function new();
      target_hum   = HUM_W'(RST_TARGET_HUM);
      vent_dur_s   = 16'(RST_VENT_DUR);
      vent_int_min = 16'(RST_VENT_INT);
      spr_on       = SPREAD_W'(RST_SPREAD_ON);
      spr_off      = SPREAD_W'(RST_SPREAD_OFF);
      heaters      = '0;
      cfan = 0; vfan = 0; venting = 0; vent_started = 0;
      armed = 0; beeping = 0; buzz = 0;
      vent_t0 = '0; last_beep = '0;
      field_name = '{"buzzer", "vent_fan", "chamber_fan", "heater_any",
                     "heater_aux2", "heater_aux1", "heater_main"};
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TARGET_HUM: target_hum   = val[HUM_W-1:0];
        CFG_VENT_DUR:   vent_dur_s   = val;
        CFG_VENT_INT:   vent_int_min = val;
        CFG_SPREAD_ON:  spr_on       = val[SPREAD_W-1:0];
        CFG_SPREAD_OFF: spr_off      = val[SPREAD_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_drives(in_item_t it);
      logic [TIME_BITS-1:0] now, since;
      longint unsigned      lim;
      int                   lvl, hi, lo, spread;
      int                   tv[4];
      out_item_t            want;

      now = it.now_ms;
      ticks++;
      // alarm request applies even in test mode
      if (it.alarm_play && !armed) begin
        armed = 1;
        last_beep = now - TIME_BITS'(BEEP_ARM_MS);
      end else if (!it.alarm_play) begin
        armed = 0;
        beeping = 0;
        buzz = 0;
      end

      if (!it.test_mode) begin
        lvl = (it.drying_active && !it.alarm_state) ? int'(it.heater_level) : 0;
        if (lvl == 1) heaters = 3'b001;
        else if (lvl == 2) heaters = 3'b110;
        else if (lvl >= 3) heaters = 3'b111;
        else heaters = 3'b000;

        if (it.boost_phase) begin
          cfan = 1;
        end else if (it.drying_active) begin
          tv[0] = int'(it.temp_a);
          tv[1] = int'(it.temp_b);
          tv[2] = int'(it.temp_c);
          tv[3] = int'(it.temp_d);
          hi = tv[0];
          lo = tv[0];
          for (int k = 1; k < 4; k++) begin
            if (tv[k] > hi) hi = tv[k];
            if (tv[k] < lo) lo = tv[k];
          end
          spread = hi - lo;
          if (!cfan && spread > int'(spr_on)) cfan = 1;
          else if (cfan && spread < int'(spr_off)) cfan = 0;
        end else begin
          cfan = 0;
        end

        if (it.drying_active && it.humidity > target_hum) begin
          since = now - vent_t0;
          if (venting) begin
            lim = longint'(vent_dur_s) * MS_PER_SEC;
            if ({32'd0, since} >= lim) begin
              venting = 0;
              vfan = 0;
            end
          end else begin
            lim = longint'(vent_int_min) * MS_PER_MIN;
            if (!vent_started || {32'd0, since} >= lim) begin
              venting = 1;
              vfan = 1;
              vent_started = 1;
              vent_t0 = now;
            end
          end
        end else begin
          vfan = 0;
          venting = 0;
          vent_started = 0;
          vent_t0 = '0;
        end

        if (armed) begin
          since = now - last_beep;
          if (since > TIME_BITS'(BEEP_PERIOD_MS)) begin
            last_beep = now;
            beeping = 1;
            buzz = 1;
          end
          since = now - last_beep;
          if (beeping && since > TIME_BITS'(BEEP_LEN_MS)) begin
            beeping = 0;
            buzz = 0;
          end
        end else begin
          buzz = 0;
        end
      end

      want.heater_main = heaters[0];
      want.heater_aux1 = heaters[1];
      want.heater_aux2 = heaters[2];
      want.heater_any  = |heaters;
      want.chamber_fan = cfan;
      want.vent_fan    = vfan;
      want.buzzer      = buzz;
      drives_due.push_back(want);
    endfunction

    function void check_drives(out_item_t got);
      out_item_t want;
      if (drives_due.size() == 0) begin
        errors++;
        $display("%0t: drive item %b arrived, expected none", $time, got);
        return;
      end
      want = drives_due.pop_front();
      checked++;
      for (int b = 6; b >= 0; b--) begin
        if (got[b] !== want[b]) begin
          errors++;
          $display("%0t: %s expected %0b actual %0b", $time, field_name[b], want[b], got[b]);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  actuator_scoreboard    sb = new();
  int unsigned           gap_odds = 3;
  int unsigned           stall_left = 0;
  int unsigned           idle_count = 0;
  int unsigned           settings = 0;
  logic [TIME_BITS-1:0]  clock_ms = '0;
  bit                    wet = 1, drying = 1, boosting = 0, playing = 0;

  dryer_actuator_sequencer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check and random stall bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_drives(out_data);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    wait (rst_n);
    while (idle_count < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_tick(in_item_t it);
    if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.predict_drives(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.drives_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_config(logic [CFG_DATA_W-1:0] hum, logic [CFG_DATA_W-1:0] dur,
                             logic [CFG_DATA_W-1:0] intv, logic [CFG_DATA_W-1:0] on,
                             logic [CFG_DATA_W-1:0] off);
    cfg_idx_e              order[5];
    logic [CFG_DATA_W-1:0] vals[5];
    order = '{CFG_TARGET_HUM, CFG_VENT_DUR, CFG_VENT_INT, CFG_SPREAD_ON, CFG_SPREAD_OFF};
    vals = '{hum, dur, intv, on, off};
    settings++;
    cfg_valid <= 1'b1;
    for (int r = 0; r < 5; r++) begin
      cfg_index <= order[r];
      cfg_data <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(order[r], vals[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned count, bit calm);
    in_item_t it;
    int       base, span, cut;
    int       tv[4];
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) gap_odds = (calm || $urandom_range(0, 2) == 0) ? 0 : 4;
      case ($urandom_range(0, 19))
        0:          clock_ms = $urandom();
        1, 2:       clock_ms += $urandom_range(5000, 120000);
        3, 4, 5, 6: clock_ms += $urandom_range(300, 5000);
        default:    clock_ms += $urandom_range(0, 300);
      endcase
      if ($urandom_range(0, 24) == 0) wet = !wet;
      if ($urandom_range(0, 39) == 0) drying = !drying;
      if ($urandom_range(0, 19) == 0) boosting = !boosting;
      if ($urandom_range(0, 29) == 0) playing = !playing;

      it.now_ms        = clock_ms;
      it.test_mode     = ($urandom_range(0, 11) == 0);
      it.drying_active = ($urandom_range(0, 29) == 0) ? !drying : drying;
      it.alarm_state   = ($urandom_range(0, 9) == 0);
      it.heater_level  = ($urandom_range(0, 4) == 0) ? 8'($urandom())
                                                    : 8'($urandom_range(0, 5)) - 8'd1;
      it.boost_phase   = boosting;
      it.alarm_play    = playing;

      // temperatures mostly straddle the spread thresholds
      span = int'(sb.spr_on) + int'(sb.spr_on) / 2 + 8;
      base = int'($urandom_range(0, 4000)) - 2000;
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 9))
          0:       tv[k] = int'($urandom_range(0, 65535));
          1:       tv[k] = base + int'($urandom_range(0, 8000)) - 4000;
          default: tv[k] = base + int'($urandom_range(0, span));
        endcase
      end
      it.temp_a = 16'(tv[0]);
      it.temp_b = 16'(tv[1]);
      it.temp_c = 16'(tv[2]);
      it.temp_d = 16'(tv[3]);

      cut = int'(sb.target_hum);
      if ($urandom_range(0, 19) == 0) it.humidity = HUM_W'($urandom_range(0, 1023));
      else if (wet && cut < 1023) it.humidity = HUM_W'($urandom_range(cut + 1, 1023));
      else it.humidity = HUM_W'($urandom_range(0, cut));
      send_tick(it);
    end
  endtask

  initial begin
    in_item_t d;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at reset register values
    d = '0;
    send_tick(d);
    d.drying_active = 1; d.now_ms = 10;
    d.heater_level = 1;    send_tick(d);
    d.heater_level = 2;    send_tick(d);
    d.heater_level = 3;    send_tick(d);
    d.heater_level = 127;  send_tick(d);
    d.heater_level = -128; send_tick(d);
    d.heater_level = 3; d.alarm_state = 1; send_tick(d);
    d.alarm_state = 0; d.drying_active = 0; d.boost_phase = 1; send_tick(d);
    d.boost_phase = 0; send_tick(d);
    d.drying_active = 1; d.temp_a = -32768; d.temp_b = 32767; send_tick(d);
    d.temp_a = 0; d.temp_b = 0; send_tick(d);
    d.temp_c = 48; send_tick(d);
    d.temp_c = 49; send_tick(d);
    d.temp_c = 16; send_tick(d);
    d.temp_c = 15; send_tick(d);
    // vent: first start, run out, restart after interval, humidity at target
    d.humidity = 1023; d.now_ms = 1000; send_tick(d);
    d.now_ms = 30999;  send_tick(d);
    d.now_ms = 31000;  send_tick(d);
    d.now_ms = 601000; send_tick(d);
    d.humidity = 400; d.now_ms = 601500; send_tick(d);
    // alarm across the time wrap, test mode hold and disarm
    d.alarm_play = 1; d.now_ms = 32'hFFFF_FF00; send_tick(d);
    d.now_ms = 32'hFFFF_FFC8; send_tick(d);
    d.now_ms = 32'h0000_0009; send_tick(d);
    d.test_mode = 1; d.now_ms = 32'h0000_0400; send_tick(d);
    d.alarm_play = 0; send_tick(d);
    d.test_mode = 0; d.alarm_play = 1; d.now_ms = 32'h0000_0500; send_tick(d);
    drain();

    load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(170, 0);
    drain();
    load_config(16'hFFE8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(170, 0);
    drain();
    load_config(16'd500, 16'd1, 16'd1, 16'd100, 16'd30);
    clock_ms = 32'hFFFF_0000;
    run_random(170, 0);
    drain();
    load_config(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 5)),
                16'($urandom_range(0, 2)), 16'($urandom_range(0, 200)),
                16'($urandom_range(0, 60)));
    run_random(170, 0);
    drain();
    load_config(16'(RST_TARGET_HUM), 16'(RST_VENT_DUR), 16'(RST_VENT_INT),
                16'(RST_SPREAD_ON), 16'(RST_SPREAD_OFF));
    run_random(170, 1);
    drain();

    $display("Ran %0d ticks under %0d register settings plus reset values,", sb.ticks, settings);
    $display("%0d drive items compared, %0d field mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
